>>> rtl/rdq_pkg.sv
// ============================================================================
// rdq_pkg
// Shared types and constants for the ring deque with remove.
// ============================================================================
package rdq_pkg;

    localparam int OP_W        = 3;
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 4;
    localparam int SLOTS_RESET = 16;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PUSH_BACK  = 3'd0;
    localparam t_op OP_PUSH_FRONT = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_REMOVE     = 3'd4;

endpackage

>>> rtl/rdq_ram.sv
// ============================================================================
// rdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ring_deque_with_remove_unit.sv
// ============================================================================
// ring_deque_with_remove_unit
// Circular double-ended queue with push/pop at both ends and remove-by-value.
// ============================================================================
// Items live in one RAM with a registered read port; a sequencer runs one
// command at a time and finishes every command by reading the head slot for
// the front value. A command is taken when start is high and busy is low; its
// result appears on the o_ ports for one cycle with o_valid, and the next
// command can be taken in that same cycle. Pushes write on acceptance; pops
// that find an item first read it from the RAM. A remove reads each entry
// from the head until it finds a match or reaches the tail; on a match past
// the head it moves each entry ahead of the match back one slot, one read and
// one write per entry through the single RAM read port, then advances the head.
// A write to the slot-count register empties the queue.
// ============================================================================
module ring_deque_with_remove_unit
    import rdq_pkg::*;
#(
    parameter int MAX_SLOTS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [VALUE_BITS-1:0] i_item_value,
    output logic                  o_valid,
    output logic                  o_ok,
    output logic [VALUE_BITS-1:0] o_out_value,
    output logic [COUNT_W-1:0]    o_item_count,
    output logic [VALUE_BITS-1:0] o_front_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (SW > CFG_W) ? SW : CFG_W;
    localparam int RESET_SLOTS = (SLOTS_RESET > MAX_SLOTS) ? MAX_SLOTS : SLOTS_RESET;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP      = 3'd1;
    localparam logic [2:0] S_PEEK_RD  = 3'd2;
    localparam logic [2:0] S_PEEK     = 3'd3;
    localparam logic [2:0] S_SCAN_RD  = 3'd4;
    localparam logic [2:0] S_SCAN     = 3'd5;
    localparam logic [2:0] S_SHIFT_RD = 3'd6;
    localparam logic [2:0] S_SHIFT_WR = 3'd7;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i, input logic [SW-1:0] n);
        logic [SW:0] t;
        t = (SW+1)'(i) + (SW+1)'(1);
        return (t >= {1'b0, n}) ? '0 : IW'(t);
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] i, input logic [SW-1:0] n);
        return (i == '0) ? IW'(n - SW'(1)) : (i - IW'(1));
    endfunction

    function automatic logic [SW-1:0] f_count(input logic [IW-1:0] h, input logic [IW-1:0] t,
                                              input logic [SW-1:0] n);
        logic [SW-1:0] c;
        if (t >= h) begin
            c = SW'(t) - SW'(h);
        end else begin
            c = n - (SW'(h) - SW'(t));
        end
        return c;
    endfunction

    logic [2:0]            r_state, n_state;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [IW-1:0]         r_s, n_s;
    logic [SW-1:0]         r_slots, n_slots;
    t_op                   r_op, n_op;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_ok, n_ok;
    logic [VALUE_BITS-1:0] r_result, n_result;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [VALUE_BITS-1:0] r_front, n_front;
    logic                  r_valid, n_valid;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                  empty;
    logic [IW-1:0]         tail_next, tail_prev, head_next, head_prev, s_next, s_prev;
    logic [CW-1:0]         cfg_clamped;

    assign empty     = (r_head == r_tail);
    assign tail_next = f_next(r_tail, r_slots);
    assign tail_prev = f_prev(r_tail, r_slots);
    assign head_next = f_next(r_head, r_slots);
    assign head_prev = f_prev(r_head, r_slots);
    assign s_next    = f_next(r_s, r_slots);
    assign s_prev    = f_prev(r_s, r_slots);

    always_comb begin
        cfg_clamped = CW'(i_cfg_wdata);
        if (cfg_clamped < CW'(2)) begin
            cfg_clamped = CW'(2);
        end else if (cfg_clamped > CW'(MAX_SLOTS)) begin
            cfg_clamped = CW'(MAX_SLOTS);
        end
    end

    rdq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_s       = r_s;
        n_slots   = r_slots;
        n_op      = r_op;
        n_val     = r_val;
        n_ok      = r_ok;
        n_result  = r_result;
        n_count   = r_count;
        n_front   = r_front;
        n_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        ram_wdata = r_val;
        ram_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_val    = i_item_value;
                    n_ok     = 1'b0;
                    n_result = '0;
                    n_state  = S_PEEK_RD;
                    case (i_op)
                        OP_PUSH_BACK: begin
                            if (tail_next != r_head) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                ram_wdata = i_item_value;
                                n_tail    = tail_next;
                                n_ok      = 1'b1;
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (head_prev != r_tail) begin
                                ram_we    = 1'b1;
                                ram_waddr = head_prev;
                                ram_wdata = i_item_value;
                                n_head    = head_prev;
                                n_ok      = 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (!empty) begin
                                ram_raddr = r_head;
                                n_state   = S_POP;
                            end
                        end
                        OP_POP_BACK: begin
                            if (!empty) begin
                                ram_raddr = tail_prev;
                                n_tail    = tail_prev;
                                n_state   = S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            n_s     = r_head;
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_PEEK_RD;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_ok     = 1'b1;
                n_result = ram_rdata;
                if (r_op == OP_POP_FRONT) begin
                    n_head = head_next;
                end
                n_state = S_PEEK_RD;
            end
            S_PEEK_RD: begin
                ram_raddr = r_head;
                n_state   = S_PEEK;
            end
            S_PEEK: begin
                n_valid = 1'b1;
                n_count = COUNT_W'(f_count(r_head, r_tail, r_slots));
                n_front = empty ? '0 : ram_rdata;
                n_state = S_IDLE;
            end
            S_SCAN_RD: begin
                if (r_s == r_tail) begin
                    n_state = S_PEEK_RD;
                end else begin
                    ram_raddr = r_s;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (ram_rdata == r_val) begin
                    if (r_s == r_head) begin
                        n_head   = head_next;
                        n_ok     = 1'b1;
                        n_result = r_val;
                        n_state  = S_PEEK_RD;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    n_s     = s_next;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = s_prev;
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_s;
                ram_wdata = ram_rdata;
                n_s       = s_prev;
                if (s_prev == r_head) begin
                    n_head   = head_next;
                    n_ok     = 1'b1;
                    n_result = r_val;
                    n_state  = S_PEEK_RD;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_slots = SW'(cfg_clamped);
            n_head  = '0;
            n_tail  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_slots <= SW'(RESET_SLOTS);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_slots <= n_slots;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_op     <= n_op;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_result <= n_result;
        r_count  <= n_count;
        r_front  <= n_front;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_out_value   = r_result;
    assign o_item_count  = r_count;
    assign o_front_value = r_front;

    a_valid_after_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_PEEK)
        else $error("result strobe without front read");

    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_head) < r_slots) && (SW'(r_tail) < r_slots))
        else $error("ring index beyond slot count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start sequencer");

    a_shift_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> (r_s != r_head))
        else $error("shift past head");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_result == '0))
        else $error("failed beat carries a value");

endmodule
